// ----- hdl/ssd_pkg.sv -----
// ssd_pkg: shared types and constants for the scaled sprite depth test block.
// No dependencies; used by ssd_front, ssd_fifo, ssd_back, ssd_chk and the top level.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int TEX_AW  = 12;  // texture store address width (4096 words)
  localparam int COL_AW  = 10;  // column depth store address width (1024 words)
  localparam int DATA_W  = 32;
  localparam int DIM_W   = 16;
  localparam int PADDR_W = 20;
  localparam int SCR_AW  = 12;  // on-screen row/column width (limits up to 4096)
  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 1 << Q_AW;

  localparam logic [1:0] FN_TEX   = 2'd0;
  localparam logic [1:0] FN_DEPTH = 2'd1;
  localparam logic [1:0] FN_PIXEL = 2'd2;

  typedef enum logic [1:0] {
    K_TEX,
    K_DEPTH,
    K_PIXEL,
    K_NONE
  } kind_t;

  // one classified word as it sits in the queue
  typedef struct packed {
    kind_t                kind;
    logic [TEX_AW-1:0]    idx;    // texture write address
    logic [DATA_W-1:0]    data;   // load value, or sprite distance for pixels
    logic [COL_AW-1:0]    col;    // depth store address (load or lookup)
    logic [DIM_W-1:0]     ci;
    logic [DIM_W-1:0]     rj;
    logic [DIM_W-1:0]     size;
    logic [PADDR_W-1:0]   paddr;
  } entry_t;

endpackage

// ----- hdl/ssd_front.sv -----
// ssd_front: classifies each input word and prepares screen address and depth index.
// Depends on ssd_pkg; feeds ssd_fifo.
`timescale 1ns / 1ps

module ssd_front #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024
) (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [ssd_pkg::TEX_AW-1:0]        in_index,
  input  logic [ssd_pkg::DATA_W-1:0]        in_value,
  input  logic [ssd_pkg::DIM_W-1:0]         in_sprite_size,
  input  logic signed [ssd_pkg::DIM_W-1:0]  in_offset_x,
  input  logic signed [ssd_pkg::DIM_W-1:0]  in_offset_y,
  input  logic [ssd_pkg::DATA_W-1:0]        in_sprite_distance,
  input  logic [ssd_pkg::DIM_W-1:0]         in_column_in_sprite,
  input  logic [ssd_pkg::DIM_W-1:0]         in_row_in_sprite,
  input  logic                              q_not_full,
  output logic                              push,
  output ssd_pkg::entry_t                   push_data
);

  localparam int PW = 2 * ssd_pkg::SCR_AW + 1;

  logic signed [ssd_pkg::DIM_W+1:0] sx;
  logic signed [ssd_pkg::DIM_W+1:0] sy;
  logic                             sx_ok;
  logic                             sy_ok;
  logic                             in_sq;
  logic [PW-1:0]                    prod;

  assign in_ready = q_not_full;
  assign push     = in_valid && q_not_full;

  // 18-bit signed sums cover the full offset and in-sprite ranges
  assign sx = $signed({{2{in_offset_x[15]}}, in_offset_x}) +
              $signed({2'b00, in_column_in_sprite});
  assign sy = $signed({{2{in_offset_y[15]}}, in_offset_y}) +
              $signed({2'b00, in_row_in_sprite});

  assign sx_ok = !sx[ssd_pkg::DIM_W+1] &&
                 (sx[ssd_pkg::DIM_W:0] < (ssd_pkg::DIM_W+1)'(SCREEN_W));
  assign sy_ok = !sy[ssd_pkg::DIM_W+1] &&
                 (sy[ssd_pkg::DIM_W:0] < (ssd_pkg::DIM_W+1)'(SCREEN_H));
  assign in_sq = (in_column_in_sprite < in_sprite_size) &&
                 (in_row_in_sprite < in_sprite_size);

  assign prod = PW'(sy[ssd_pkg::SCR_AW-1:0]) * PW'(SCREEN_W);

  always_comb begin
    push_data.idx   = in_index;
    push_data.data  = (in_func == ssd_pkg::FN_PIXEL) ? in_sprite_distance : in_value;
    push_data.col   = (in_func == ssd_pkg::FN_DEPTH) ? in_index[ssd_pkg::COL_AW-1:0]
                                                     : sx[ssd_pkg::COL_AW-1:0];
    push_data.ci    = in_column_in_sprite;
    push_data.rj    = in_row_in_sprite;
    push_data.size  = in_sprite_size;
    push_data.paddr = ssd_pkg::PADDR_W'(prod + PW'(sx[ssd_pkg::SCR_AW-1:0]));
    unique case (in_func)
      ssd_pkg::FN_TEX:   push_data.kind = ssd_pkg::K_TEX;
      ssd_pkg::FN_DEPTH: push_data.kind = ssd_pkg::K_DEPTH;
      ssd_pkg::FN_PIXEL: push_data.kind = (in_sq && sx_ok && sy_ok) ? ssd_pkg::K_PIXEL
                                                                     : ssd_pkg::K_NONE;
      default:           push_data.kind = ssd_pkg::K_NONE;
    endcase
  end

endmodule

// ----- hdl/ssd_fifo.sv -----
// ssd_fifo: short queue of classified words between front and back.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssd_pkg::entry_t push_data,
  input  logic            pop,
  output ssd_pkg::entry_t head,
  output logic            not_empty,
  output logic            not_full
);

  ssd_pkg::entry_t            mem_r [ssd_pkg::Q_DEPTH];
  logic [ssd_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [ssd_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [ssd_pkg::Q_AW:0]     cnt_r;
  logic                       do_push;
  logic                       do_pop;

  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != (ssd_pkg::Q_AW+1)'(ssd_pkg::Q_DEPTH));
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- hdl/ssd_div.sv -----
// ssd_div: restoring divider for TILE*n/size, one quotient bit per cycle.
// No package dependency; used by ssd_back. Requires n < den.
`timescale 1ns / 1ps

module ssd_div #(
  parameter int TILE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [15:0]               num,
  input  logic [15:0]               den,
  output logic                      done,
  output logic [$clog2(TILE)-1:0]   quo
);

  localparam int QW = $clog2(TILE);
  localparam int DW = 16 + QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] dividend;
  logic [15:0]   rem_r;
  logic [15:0]   den_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [16:0]   trial;
  logic          ge;
  logic [15:0]   diff;

  // n < den keeps the quotient below 2^QW, so the top part starts below den
  assign dividend = DW'(num) * DW'(TILE);
  assign trial    = {rem_r, lo_r[QW-1]};
  assign ge       = (trial >= {1'b0, den_r});
  assign diff     = 16'(trial - {1'b0, den_r});
  assign done     = done_r;
  assign quo      = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 16'(dividend >> QW);
      lo_r  <= dividend[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff : trial[15:0];
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

endmodule

// ----- hdl/ssd_back.sv -----
// ssd_back: executes queued words: store writes, depth test, texture sampling, result register.
// Depends on ssd_pkg and ssd_div.
`timescale 1ns / 1ps

module ssd_back #(
  parameter int TILE = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ssd_pkg::entry_t               head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_write_pixel,
  output logic [ssd_pkg::PADDR_W-1:0]   out_pixel_address,
  output logic [ssd_pkg::DATA_W-1:0]    out_colour
);

  localparam int QW = $clog2(TILE);
  localparam int MW = 2 * QW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEPTH,
    S_DIVC,
    S_DIVR,
    S_TEX,
    S_OUT
  } state_t;

  state_t                        state_r;
  ssd_pkg::entry_t               cur_r;
  logic [QW-1:0]                 qc_r;
  logic                          wp_r;
  logic [ssd_pkg::PADDR_W-1:0]   addr_r;
  logic [ssd_pkg::DATA_W-1:0]    colour_r;

  logic [ssd_pkg::DATA_W-1:0]    tex_mem_r [1 << ssd_pkg::TEX_AW];
  logic [ssd_pkg::DATA_W-1:0]    dep_mem_r [1 << ssd_pkg::COL_AW];
  logic [ssd_pkg::DATA_W-1:0]    tex_rd_r;
  logic [ssd_pkg::DATA_W-1:0]    dep_rd_r;
  logic [ssd_pkg::DATA_W-1:0]    word0_r;

  logic                          tex_we;
  logic                          dep_we;
  logic                          tex_re;
  logic                          depth_pass;
  logic                          div_start;
  logic [15:0]                   div_num;
  logic                          div_done;
  logic [QW-1:0]                 div_q;
  logic [ssd_pkg::TEX_AW-1:0]    tex_ra;

  assign pop        = (state_r == S_IDLE) && q_valid;
  assign tex_we     = pop && (head.kind == ssd_pkg::K_TEX);
  assign dep_we     = pop && (head.kind == ssd_pkg::K_DEPTH);
  assign depth_pass = (dep_rd_r > cur_r.data);
  assign div_start  = ((state_r == S_DEPTH) && depth_pass) ||
                      ((state_r == S_DIVC) && div_done);
  assign div_num    = (state_r == S_DEPTH) ? cur_r.ci : cur_r.rj;
  assign tex_re     = (state_r == S_DIVR) && div_done;
  // row quotient arrives now, column quotient was saved; address wraps to the store
  assign tex_ra     = ssd_pkg::TEX_AW'(MW'(TILE) * MW'(div_q) + MW'(qc_r));

  assign out_valid         = (state_r == S_OUT);
  assign out_write_pixel   = wp_r;
  assign out_pixel_address = addr_r;
  assign out_colour        = colour_r;

  ssd_div #(.TILE(TILE)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cur_r.size),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (tex_we) tex_mem_r[head.idx] <= head.data;
    if (tex_re) tex_rd_r <= tex_mem_r[tex_ra];
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem_r[head.col] <= head.data;
    if (pop)    dep_rd_r <= dep_mem_r[head.col];
  end

  // transparent key kept aside so the sample needs one read port only
  always_ff @(posedge clk) begin
    if (tex_we && (head.idx == '0)) word0_r <= head.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r    <= head;
            wp_r     <= 1'b0;
            addr_r   <= '0;
            colour_r <= '0;
            state_r  <= (head.kind == ssd_pkg::K_PIXEL) ? S_DEPTH : S_OUT;
          end
        end
        S_DEPTH: begin
          state_r <= depth_pass ? S_DIVC : S_OUT;
        end
        S_DIVC: begin
          if (div_done) begin
            qc_r    <= div_q;
            state_r <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_done) state_r <= S_TEX;
        end
        S_TEX: begin
          if (tex_rd_r != word0_r) begin
            wp_r     <= 1'b1;
            addr_r   <= cur_r.paddr;
            colour_r <= tex_rd_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/scaled_sprite_pixel_depth_test_core.sv -----
// Channel  Dir  Handshake            Word
// in_      in   in_valid/in_ready    func, index, value, sprite geometry, distance
// out_     out  out_valid/out_ready  write_pixel, pixel_address, colour
//
// Loads and words rejected in the front pass the back end's idle and output states; a
// pixel failing the depth test also passes the depth state; a passing pixel goes on
// through the column and row divide states, which share the restoring divider, and
// the texture state. A result waits in the output state for out_ready. The front queue
// holds 4 words, so input keeps flowing while the back end works or its result waits,
// until the queue fills. Reset is synchronous and clears control only; the texture
// and depth stores hold garbage until written.
// Top level: instantiates ssd_front, ssd_fifo and ssd_back; depends on ssd_pkg.
`timescale 1ns / 1ps

module scaled_sprite_pixel_depth_test_core #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024,
  parameter int TILE     = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [ssd_pkg::TEX_AW-1:0]        in_index,
  input  logic [ssd_pkg::DATA_W-1:0]        in_value,
  input  logic [ssd_pkg::DIM_W-1:0]         in_sprite_size,
  input  logic signed [ssd_pkg::DIM_W-1:0]  in_offset_x,
  input  logic signed [ssd_pkg::DIM_W-1:0]  in_offset_y,
  input  logic [ssd_pkg::DATA_W-1:0]        in_sprite_distance,
  input  logic [ssd_pkg::DIM_W-1:0]         in_column_in_sprite,
  input  logic [ssd_pkg::DIM_W-1:0]         in_row_in_sprite,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_write_pixel,
  output logic [ssd_pkg::PADDR_W-1:0]       out_pixel_address,
  output logic [ssd_pkg::DATA_W-1:0]        out_colour
);

  logic            q_not_full;
  logic            q_not_empty;
  logic            push;
  logic            pop;
  ssd_pkg::entry_t push_data;
  ssd_pkg::entry_t head;

  ssd_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_index            (in_index),
    .in_value            (in_value),
    .in_sprite_size      (in_sprite_size),
    .in_offset_x         (in_offset_x),
    .in_offset_y         (in_offset_y),
    .in_sprite_distance  (in_sprite_distance),
    .in_column_in_sprite (in_column_in_sprite),
    .in_row_in_sprite    (in_row_in_sprite),
    .q_not_full          (q_not_full),
    .push                (push),
    .push_data           (push_data)
  );

  ssd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  ssd_back #(.TILE(TILE)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_not_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_pixel   (out_write_pixel),
    .out_pixel_address (out_pixel_address),
    .out_colour        (out_colour)
  );

endmodule

// ----- hdl/ssd_chk.sv -----
// ssd_chk: port-level checks for the sprite depth test top level, plus its bind.
// Depends on ssd_pkg for the queue depth and the port widths.
`timescale 1ns / 1ps

module ssd_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_write_pixel,
  input logic [ssd_pkg::PADDR_W-1:0]     out_pixel_address,
  input logic [ssd_pkg::DATA_W-1:0]      out_colour
);

  logic [3:0] pend_r;
  logic [3:0] pend_nxt;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (acc_in && !acc_out)      pend_nxt = pend_r + 1'b1;
    else if (acc_out && !acc_in) pend_nxt = pend_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_nxt;
  end

  // a result never shows up without an accepted word behind it
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result word without a pending input word");

  // queue plus the word in the back end bound the words in flight
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'(ssd_pkg::Q_DEPTH + 1))
    else $error("more words in flight than the block can hold");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_pixel) |-> (out_pixel_address == '0 && out_colour == '0))
    else $error("non-write result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_write_pixel) &&
                                   $stable(out_pixel_address) && $stable(out_colour)))
    else $error("stalled result word changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind scaled_sprite_pixel_depth_test_core ssd_chk u_chk (.*);
